// ----- rtl/cron_schedule_matcher_core_defines.svh -----
// Assertion helpers for the schedule matcher core.
`ifndef CRON_SCHEDULE_MATCHER_CORE_DEFINES_SVH
`define CRON_SCHEDULE_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define CSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define CSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/csm_pkg.sv -----
package csm_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int LIST_SLOTS  = 8;
    localparam int NUM_FIELDS  = 5;
    localparam int NUM_CELLS   = NUM_ENTRIES * NUM_FIELDS;
    localparam int CELL_W      = $clog2(NUM_CELLS);
    localparam int SLOT_W      = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
    localparam int ENT_IDX_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int HITS_W      = $clog2(NUM_ENTRIES + 1);

    // command codes; 5..7 are unused
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_SPEC   = 3'd1;
    localparam logic [2:0] CMD_APPEND = 3'd2;
    localparam logic [2:0] CMD_ENABLE = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    // field indexes
    localparam logic [2:0] FLD_MINUTE = 3'd0;
    localparam logic [2:0] FLD_HOUR   = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_MONTH  = 3'd3;
    localparam logic [2:0] FLD_WDAY   = 3'd4;

    typedef enum logic [1:0] {
        KIND_ANY   = 2'd0,
        KIND_EXACT = 2'd1,
        KIND_RANGE = 2'd2,
        KIND_LIST  = 2'd3
    } csm_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SCAN,
        ST_SCAN_END,
        ST_EMIT
    } csm_state_t;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] entry_index;
        logic [2:0] field_index;
        logic [1:0] spec_kind;
        logic [6:0] first_value;
        logic [6:0] second_value;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [2:0] weekday;
    } csm_in_t;

    typedef struct packed {
        logic [4:0] matched_entry;
        logic       hit;
        logic       last;
    } csm_out_t;

    typedef struct packed {
        csm_kind_t  kind;
        logic [6:0] low;
        logic [6:0] high;
        logic [3:0] count;
    } csm_cell_t;

    typedef logic [LIST_SLOTS-1:0][6:0] csm_list_row_t;

    // controller to datapath
    typedef struct packed {
        logic in_take;
        logic app_commit;
        logic scan_adv;
        logic emit_adv;
        logic push_hit;
        logic push_nohit;
    } csm_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic take_append;
        logic take_tick;
        logic scan_last;
        logic no_hits;
        logic emit_done;
        logic cur_hit;
        logic out_free;
    } csm_sts_t;

endpackage

// ----- rtl/csm_datapath.sv -----
module csm_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  csm_pkg::csm_in_t   s_data,
    input  csm_pkg::csm_ctl_t  ctl,
    output csm_pkg::csm_sts_t  sts,
    output logic               m_valid,
    output csm_pkg::csm_out_t  m_data,
    input  logic               m_ready
);
    import csm_pkg::*;

    // storage
    csm_cell_t               cell_mem [NUM_CELLS];
    csm_list_row_t           list_mem [NUM_CELLS];
    logic [NUM_CELLS-1:0]    cell_vld_reg;
    logic [NUM_ENTRIES-1:0]  en_reg;

    csm_in_t                 item_reg;
    csm_cell_t               rd_cell_reg;
    csm_list_row_t           rd_list_reg;
    logic                    rd_vld_reg;
    logic [CELL_W-1:0]       app_cell_reg;

    logic [CELL_W-1:0]       scan_cell_reg;
    logic [2:0]              scan_field_reg;
    logic [ENT_IDX_W-1:0]    scan_entry_reg;
    logic                    s2_vld_reg;
    logic [2:0]              s2_field_reg;
    logic [ENT_IDX_W-1:0]    s2_entry_reg;
    logic                    ok_reg;
    logic [NUM_ENTRIES-1:0]  hit_vec_reg;
    logic [HITS_W-1:0]       hit_cnt_reg;
    logic [ENT_IDX_W-1:0]    emit_idx_reg;
    logic [HITS_W-1:0]       emitted_reg;

    logic                    m_valid_reg;
    csm_out_t                m_data_reg;

    // input decode
    logic                    addr_ok;
    logic                    field_ok;
    logic [CELL_W-1:0]       in_cell;
    logic [CELL_W-1:0]       clr_base;
    logic [ENT_IDX_W-1:0]    in_entry;
    logic                    do_clear;
    logic                    do_enable;
    logic                    do_spec;
    logic                    do_app_rd;
    logic                    do_scan_init;

    assign addr_ok  = 32'(s_data.entry_index) < NUM_ENTRIES;
    assign field_ok = 32'(s_data.field_index) < NUM_FIELDS;
    assign in_entry = ENT_IDX_W'(s_data.entry_index);
    assign clr_base = CELL_W'(32'(s_data.entry_index) * NUM_FIELDS);
    assign in_cell  = CELL_W'(32'(s_data.entry_index) * NUM_FIELDS
                              + 32'(s_data.field_index));

    assign do_clear     = ctl.in_take && addr_ok && s_data.command == CMD_CLEAR;
    assign do_enable    = ctl.in_take && addr_ok && s_data.command == CMD_ENABLE;
    assign do_spec      = ctl.in_take && addr_ok && field_ok && s_data.command == CMD_SPEC;
    assign do_app_rd    = ctl.in_take && sts.take_append;
    assign do_scan_init = ctl.in_take && sts.take_tick;

    // append: effective cell contents and commit
    csm_cell_t               eff_cell;
    logic                    app_room;
    logic                    do_commit;
    csm_list_row_t           app_row;

    assign eff_cell  = rd_vld_reg ? rd_cell_reg
                     : '{kind: KIND_ANY, low: '0, high: '0, count: '0};
    assign app_room  = 32'(eff_cell.count) < LIST_SLOTS;
    assign do_commit = ctl.app_commit && app_room;

    always_comb begin
        app_row = rd_list_reg;
        app_row[SLOT_W'(eff_cell.count)] = item_reg.first_value;
    end

    // cell write port
    logic                    wr_en;
    logic [CELL_W-1:0]       wr_addr;
    csm_cell_t               wr_cell;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = in_cell;
        wr_cell = '{kind: csm_kind_t'(s_data.spec_kind), low: s_data.first_value,
                    high: s_data.second_value, count: '0};
        if (do_spec) begin
            wr_en = 1'b1;
        end else if (do_commit) begin
            wr_en   = 1'b1;
            wr_addr = app_cell_reg;
            wr_cell = '{kind: eff_cell.kind, low: eff_cell.low, high: eff_cell.high,
                        count: eff_cell.count + 4'd1};
        end
    end

    // read port: scan walk or append lookup
    logic [CELL_W-1:0]       rd_addr;
    logic                    rd_en;

    assign rd_addr = ctl.scan_adv ? scan_cell_reg : in_cell;
    assign rd_en   = ctl.scan_adv || do_app_rd;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[wr_addr] <= wr_cell;
        end
        if (do_commit) begin
            list_mem[app_cell_reg] <= app_row;
        end
        if (rd_en) begin
            rd_cell_reg <= cell_mem[rd_addr];
            rd_list_reg <= list_mem[rd_addr];
            rd_vld_reg  <= cell_vld_reg[rd_addr];
        end
        if (do_app_rd) begin
            app_cell_reg <= in_cell;
        end
        if (ctl.in_take) begin
            item_reg <= s_data;
        end
    end

    // valid bits and enables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_vld_reg <= '0;
            en_reg       <= '0;
        end else begin
            if (do_clear) begin
                for (int j = 0; j < NUM_FIELDS; j++) begin
                    cell_vld_reg[clr_base + CELL_W'(j)] <= 1'b0;
                end
                en_reg[in_entry] <= 1'b0;
            end
            if (do_enable) begin
                en_reg[in_entry] <= 1'b1;
            end
            if (wr_en) begin
                cell_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // field match for the cell read last cycle
    logic [6:0]              tv;
    logic                    fld_match;
    logic                    run_ok;

    always_comb begin
        case (s2_field_reg)
            FLD_MINUTE: tv = 7'(item_reg.minute);
            FLD_HOUR:   tv = 7'(item_reg.hour);
            FLD_DAY:    tv = 7'(item_reg.day_of_month);
            FLD_MONTH:  tv = 7'(item_reg.month);
            FLD_WDAY:   tv = 7'(item_reg.weekday);
            default:    tv = '0;
        endcase
    end

    always_comb begin
        fld_match = 1'b0;
        case (eff_cell.kind)
            KIND_ANY:   fld_match = 1'b1;
            KIND_EXACT: fld_match = (tv == eff_cell.low);
            KIND_RANGE: fld_match = (eff_cell.low <= tv) && (tv <= eff_cell.high);
            KIND_LIST: begin
                for (int i = 0; i < LIST_SLOTS; i++) begin
                    if (4'(i) < eff_cell.count && rd_list_reg[i] == tv) begin
                        fld_match = 1'b1;
                    end
                end
            end
            default:    fld_match = 1'b0;
        endcase
        run_ok = fld_match && ((s2_field_reg == FLD_MINUTE) ? en_reg[s2_entry_reg] : ok_reg);
    end

    // scan walk, hit collection and emit walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cell_reg  <= '0;
            scan_field_reg <= '0;
            scan_entry_reg <= '0;
            s2_vld_reg     <= 1'b0;
            s2_field_reg   <= '0;
            s2_entry_reg   <= '0;
            ok_reg         <= 1'b0;
            hit_vec_reg    <= '0;
            hit_cnt_reg    <= '0;
            emit_idx_reg   <= '0;
            emitted_reg    <= '0;
        end else begin
            s2_vld_reg <= ctl.scan_adv;
            if (ctl.scan_adv) begin
                s2_field_reg  <= scan_field_reg;
                s2_entry_reg  <= scan_entry_reg;
                scan_cell_reg <= scan_cell_reg + CELL_W'(1);
                if (scan_field_reg == FLD_WDAY) begin
                    scan_field_reg <= FLD_MINUTE;
                    scan_entry_reg <= scan_entry_reg + ENT_IDX_W'(1);
                end else begin
                    scan_field_reg <= scan_field_reg + 3'd1;
                end
            end
            if (s2_vld_reg) begin
                ok_reg <= run_ok;
                if (s2_field_reg == FLD_WDAY && run_ok) begin
                    hit_vec_reg[s2_entry_reg] <= 1'b1;
                    hit_cnt_reg <= hit_cnt_reg + HITS_W'(1);
                end
            end
            if (ctl.emit_adv) begin
                emit_idx_reg <= emit_idx_reg + ENT_IDX_W'(1);
            end
            if (ctl.push_hit) begin
                emitted_reg <= emitted_reg + HITS_W'(1);
            end
            if (do_scan_init) begin
                scan_cell_reg  <= '0;
                scan_field_reg <= FLD_MINUTE;
                scan_entry_reg <= '0;
                hit_vec_reg    <= '0;
                hit_cnt_reg    <= '0;
                emit_idx_reg   <= '0;
                emitted_reg    <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.push_hit || ctl.push_nohit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push_hit) begin
            m_data_reg <= '{matched_entry: 5'(emit_idx_reg), hit: 1'b1,
                           last: (emitted_reg + HITS_W'(1)) == hit_cnt_reg};
        end else if (ctl.push_nohit) begin
            m_data_reg <= '{matched_entry: '0, hit: 1'b0, last: 1'b1};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // status
    assign sts.take_append = addr_ok && field_ok && s_data.command == CMD_APPEND;
    assign sts.take_tick   = s_data.command == CMD_TICK;
    assign sts.scan_last   = scan_cell_reg == CELL_W'(NUM_CELLS - 1);
    assign sts.no_hits     = hit_cnt_reg == '0;
    assign sts.emit_done   = emitted_reg == hit_cnt_reg;
    assign sts.cur_hit     = hit_vec_reg[emit_idx_reg];
    assign sts.out_free    = !m_valid_reg || m_ready;

endmodule

// ----- rtl/csm_ctrl.sv -----
module csm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  csm_pkg::csm_sts_t  sts,
    output csm_pkg::csm_ctl_t  ctl
);
    import csm_pkg::*;

    csm_state_t state_reg;
    csm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && sts.take_append) begin
                    state_next = ST_APPEND;
                end else if (s_valid && sts.take_tick) begin
                    state_next = ST_SCAN;
                end
            end
            ST_APPEND:   state_next = ST_IDLE;
            ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts.no_hits) begin
                    if (sts.out_free) begin
                        state_next = ST_IDLE;
                    end
                end else if (sts.emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        ctl     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                ctl.in_take = s_valid;
            end
            ST_APPEND: begin
                ctl.app_commit = 1'b1;
            end
            ST_SCAN: begin
                ctl.scan_adv = 1'b1;
            end
            ST_SCAN_END: begin
            end
            ST_EMIT: begin
                if (sts.no_hits) begin
                    ctl.push_nohit = sts.out_free;
                end else if (!sts.emit_done) begin
                    if (sts.cur_hit) begin
                        ctl.push_hit = sts.out_free;
                        ctl.emit_adv = sts.out_free;
                    end else begin
                        ctl.emit_adv = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/cron_schedule_matcher_core.sv -----
// Write commands are taken in the idle state; an append reads the field cell, then updates it.
// A tick walks all NUM_CELLS cells of the field table one cell per cycle, then walks the
// hit list one entry per cycle (holding while the output stalls) up to the last hit, or sends
// a single no-hit result. The first result is registered at the output after the table walk;
// one item in work at a time.
// Reset (aresetn low, synchronous) disables all entries and marks every field "any".
`include "cron_schedule_matcher_core_defines.svh"

module cron_schedule_matcher_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  csm_pkg::csm_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output csm_pkg::csm_out_t  m_data
);
    import csm_pkg::*;

    csm_ctl_t ctl;
    csm_sts_t sts;

    csm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    csm_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctl     (ctl),
        .sts     (sts),
        .m_valid (m_valid),
        .m_data  (m_data),
        .m_ready (m_ready)
    );

    // a no-hit result is always the only and last one of its tick
    `CSM_ASSERT_IMP(a_nohit_last, m_valid && !m_data.hit, m_data.last, "no-hit not last")
    `CSM_ASSERT_IMP(a_nohit_zero, m_valid && !m_data.hit, m_data.matched_entry == 5'd0,
                    "no-hit entry not zero")
    // a tick holds off intake while the table is walked
    `CSM_ASSERT_NXT(a_tick_busy, s_valid && s_ready && s_data.command == CMD_TICK, !s_ready,
                    "input taken during tick scan")

endmodule
